@@ sv/efba_pkg.sv @@
// Shared constants and codes for the exact-fit reuse bump allocator.
package efba_pkg;

	// Default sizing of the block table and of heap offsets.
	localparam int MAX_BLOCKS_DEF  = 64;
	localparam int OFFSET_BITS_DEF = 24;

	// Field widths of the request, response and register words.
	localparam int OPCODE_W  = 2;
	localparam int SIZE_W    = 24;
	localparam int ADDR_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int HEAP_W    = 24;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// A rounded size can reach one bit past the request width.
	localparam int RSIZE_W = SIZE_W + 1;

	// Bytes of header in front of every payload.
	localparam int HDR_BYTES = 8;

	// Request opcodes.
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_MEMORY_BASE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEAP_START  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEAP_LIMIT  = 2'd2;

endpackage

@@ sv/efba_if.sv @@
// Request and response channel interfaces of the allocator.
interface efba_req_if;
	logic                             valid;
	logic                             ready;
	logic [efba_pkg::OPCODE_W-1:0]    opcode;
	logic [efba_pkg::SIZE_W-1:0]      req_size;
	logic [efba_pkg::ADDR_W-1:0]      free_addr;

	modport source (output valid, opcode, req_size, free_addr, input ready);
	modport sink   (input valid, opcode, req_size, free_addr, output ready);
endinterface

interface efba_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [efba_pkg::ADDR_W-1:0]      addr;
	logic [efba_pkg::STATUS_W-1:0]    status;
	logic                             reused;

	modport source (output valid, addr, status, reused, input ready);
	modport sink   (input valid, addr, status, reused, output ready);
endinterface

@@ sv/exact_fit_reuse_bump_allocator.sv @@
// Heap allocator with exact-fit reuse of freed blocks and bump allocation.
//
// A request word on req carries an opcode (allocate, free, clear), a size and
// a payload address; every request yields exactly one response word on rsp
// with the payload address, a status and a reuse flag. Registers memory_base,
// heap_start and heap_limit are written through cfg_we, cfg_idx and cfg_data;
// the user writes them only while the block is idle, which it does not enforce.
// Allocate and free walk the block table from the newest entry to the oldest,
// one entry per cycle through the table memory's single read port; a hit ends
// the walk early. Clear and unused opcodes, and a free on an empty table,
// respond at the edge that accepts them. One request is worked on at a time;
// req is ready in the idle state once the response register is free or being
// emptied.
// Reset empties the table, loads the bump offset from heap_start's reset
// value and restores the register reset values. The table memory needs no
// clearing pass. When the receiver stalls, the response is held in its
// register and no new request is taken until it leaves.
module exact_fit_reuse_bump_allocator #(
	parameter int MAX_BLOCKS  = efba_pkg::MAX_BLOCKS_DEF,
	parameter int OFFSET_BITS = efba_pkg::OFFSET_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	efba_req_if.sink                         req,
	efba_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [efba_pkg::REG_IDX_W-1:0]   cfg_idx,
	input  logic [efba_pkg::CFG_W-1:0]       cfg_data
);

	localparam int IdxW = $clog2(MAX_BLOCKS);
	localparam int CntW = $clog2(MAX_BLOCKS + 1);
	localparam int EndW = ((OFFSET_BITS > efba_pkg::RSIZE_W) ? OFFSET_BITS
		: efba_pkg::RSIZE_W) + 3;
	localparam logic [EndW-1:0] OffMask = EndW'((64'd1 << OFFSET_BITS) - 64'd1);
	localparam logic [CntW-1:0] CntMax  = CntW'(MAX_BLOCKS);

	// One table entry: block start offset, rounded payload size, free flag.
	typedef struct packed {
		logic [OFFSET_BITS-1:0]            start;
		logic [efba_pkg::RSIZE_W-1:0]      size;
		logic                              free;
	} entry_t;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_BUMP} state_t;

	state_t                            state_q;
	logic [CntW-1:0]                   cnt_q;
	logic [OFFSET_BITS-1:0]            bump_q;
	logic [IdxW-1:0]                   idx_q;
	logic                              is_free_q;
	logic [efba_pkg::RSIZE_W-1:0]      size_q;
	logic [efba_pkg::ADDR_W-1:0]       faddr_q;
	logic                              rsp_valid_q;
	logic [efba_pkg::ADDR_W-1:0]       rsp_addr_q;
	logic [efba_pkg::STATUS_W-1:0]     rsp_status_q;
	logic                              rsp_reused_q;

	logic [efba_pkg::ADDR_W-1:0]       memory_base_q;
	logic [efba_pkg::HEAP_W-1:0]       heap_start_q;
	logic [efba_pkg::HEAP_W-1:0]       heap_limit_q;

	entry_t                            mem [MAX_BLOCKS];
	entry_t                            rdata_q;
	logic [IdxW-1:0]                   rd_idx;
	logic                              mem_we;
	logic [IdxW-1:0]                   mem_waddr;
	entry_t                            mem_wdata;

	logic                              req_fire;
	logic [efba_pkg::RSIZE_W-1:0]      size_round;
	logic [OFFSET_BITS-1:0]            pa_start;
	logic [efba_pkg::ADDR_W-1:0]       pay_addr;
	logic                              hit;
	logic [EndW-1:0]                   limit;
	logic [EndW-1:0]                   new_start;
	logic [EndW-1:0]                   new_end;
	logic                              no_room;
	logic                              full;

	// Handshake of the two channels.
	assign req.ready  = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire   = req.valid && req.ready;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.addr   = rsp_addr_q;
	assign rsp.status = rsp_status_q;
	assign rsp.reused = rsp_reused_q;

	// Request size rounded up to a multiple of eight.
	assign size_round = (efba_pkg::RSIZE_W'(req.req_size) + efba_pkg::RSIZE_W'(7))
		& ~efba_pkg::RSIZE_W'(7);

	// Shared payload address adder: table entry during the walk, new block after it.
	assign pa_start = (state_q == S_SCAN) ? rdata_q.start : OFFSET_BITS'(new_start);
	assign pay_addr = memory_base_q + efba_pkg::ADDR_W'(pa_start)
		+ efba_pkg::ADDR_W'(efba_pkg::HDR_BYTES);

	// Match test for the entry read in the previous cycle.
	assign hit = is_free_q ? (pay_addr == faddr_q)
		: (rdata_q.free && (rdata_q.size == size_q));

	// Bump placement: align to four, add header and payload, check the limit.
	assign limit     = (EndW'(heap_limit_q) > OffMask) ? OffMask : EndW'(heap_limit_q);
	assign new_start = (EndW'(bump_q) + EndW'(3)) & ~EndW'(3);
	assign new_end   = new_start + EndW'(efba_pkg::HDR_BYTES) + EndW'(size_q);
	assign no_room   = new_end > limit;
	assign full      = cnt_q >= CntMax;

	// Read address leads the walk, naming the entry that is tested in the next cycle.
	assign rd_idx = (state_q == S_IDLE) ? IdxW'(cnt_q - CntW'(1)) : IdxW'(idx_q - IdxW'(1));

	// Table write: a hit updates the free flag, a bump adds a new entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rdata_q;
		mem_wdata.free = is_free_q;
		if (state_q == S_SCAN && hit) begin
			mem_we = 1'b1;
		end else if (state_q == S_BUMP && !no_room && !full) begin
			mem_we          = 1'b1;
			mem_waddr       = IdxW'(cnt_q);
			mem_wdata.start = OFFSET_BITS'(new_start);
			mem_wdata.size  = size_q;
			mem_wdata.free  = 1'b0;
		end
	end

	// Block table memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[rd_idx];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_base_q <= '0;
			heap_start_q  <= '0;
			heap_limit_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				efba_pkg::REG_MEMORY_BASE: memory_base_q <= cfg_data;
				efba_pkg::REG_HEAP_START:  heap_start_q  <= efba_pkg::HEAP_W'(cfg_data);
				efba_pkg::REG_HEAP_LIMIT:  heap_limit_q  <= efba_pkg::HEAP_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// Sequencer, allocator state and response register. The response register
	// is empty while a walk runs, so it only drains in the idle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			bump_q       <= '0;
			idx_q        <= '0;
			is_free_q    <= 1'b0;
			size_q       <= '0;
			faddr_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_addr_q   <= '0;
			rsp_status_q <= efba_pkg::ST_OK;
			rsp_reused_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						size_q    <= size_round;
						faddr_q   <= req.free_addr;
						idx_q     <= IdxW'(cnt_q - CntW'(1));
						is_free_q <= (req.opcode == efba_pkg::OP_FREE);
						rsp_addr_q   <= '0;
						rsp_reused_q <= 1'b0;
						unique case (req.opcode)
							efba_pkg::OP_ALLOC: begin
								rsp_valid_q <= 1'b0;
								state_q <= (cnt_q == '0) ? S_BUMP : S_SCAN;
							end
							efba_pkg::OP_FREE: begin
								if (cnt_q == '0) begin
									rsp_valid_q  <= 1'b1;
									rsp_status_q <= efba_pkg::ST_IGNORED;
								end else begin
									rsp_valid_q <= 1'b0;
									state_q     <= S_SCAN;
								end
							end
							efba_pkg::OP_CLEAR: begin
								cnt_q        <= '0;
								bump_q       <= OFFSET_BITS'(heap_start_q);
								rsp_valid_q  <= 1'b1;
								rsp_status_q <= efba_pkg::ST_OK;
							end
							default: begin
								rsp_valid_q  <= 1'b1;
								rsp_status_q <= efba_pkg::ST_IGNORED;
							end
						endcase
					end else if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q      <= S_IDLE;
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= efba_pkg::ST_OK;
						rsp_addr_q   <= is_free_q ? '0 : pay_addr;
						rsp_reused_q <= !is_free_q;
					end else if (idx_q == '0) begin
						if (is_free_q) begin
							state_q      <= S_IDLE;
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= efba_pkg::ST_IGNORED;
						end else begin
							state_q <= S_BUMP;
						end
					end else begin
						idx_q <= idx_q - IdxW'(1);
					end
				end
				S_BUMP: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
					if (no_room) begin
						rsp_status_q <= efba_pkg::ST_NO_ROOM;
					end else if (full) begin
						rsp_status_q <= efba_pkg::ST_FULL;
					end else begin
						rsp_status_q <= efba_pkg::ST_OK;
						rsp_addr_q   <= pay_addr;
						cnt_q        <= cnt_q + CntW'(1);
						bump_q       <= OFFSET_BITS'(new_end);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The response register is empty whenever a walk or a placement is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !rsp_valid_q)
		else $error("response pending while a request is in progress");

	// The table never holds more entries than it has rows.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntMax)
		else $error("block count exceeds table depth");

	// A clear empties the table and responds at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.opcode == efba_pkg::OP_CLEAR) |=> (cnt_q == '0 && rsp_valid_q))
		else $error("clear did not empty the table");

	// A walk only ends in a placement for an allocate request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUMP) |-> !is_free_q)
		else $error("free request reached bump placement");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the exact-fit reuse bump allocator.
module tb_top;

	localparam int CLK_PERIOD    = 10;
	localparam int NBLK          = efba_pkg::MAX_BLOCKS_DEF;
	localparam int SETTLE_CYCLES = efba_pkg::MAX_BLOCKS_DEF + 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 225;
	localparam int NUM_PHASES    = 8;
	localparam int TIMEOUT_CYC   = 800000;
	localparam int SHOWN_ERRORS  = 10;

	// The request opcode that the block must ignore.
	localparam logic [efba_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [efba_pkg::OPCODE_W-1:0] opcode;
		logic [efba_pkg::SIZE_W-1:0]   req_size;
		logic [efba_pkg::ADDR_W-1:0]   free_addr;
	} heap_req_t;

	typedef struct packed {
		logic [efba_pkg::ADDR_W-1:0]   addr;
		logic [efba_pkg::STATUS_W-1:0] status;
		logic                          reused;
	} heap_rsp_t;

	typedef struct packed {
		heap_req_t req;
		logic      typed;
		heap_rsp_t want;
	} heap_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                           cfg_we;
	logic [efba_pkg::REG_IDX_W-1:0] cfg_idx;
	logic [efba_pkg::CFG_W-1:0]     cfg_data;

	efba_req_if req_ch ();
	efba_rsp_if rsp_ch ();

	exact_fit_reuse_bump_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the heap table, the bump offset and the registers.
	logic [efba_pkg::HEAP_W-1:0]  blk_start [NBLK];
	logic [efba_pkg::RSIZE_W-1:0] blk_size  [NBLK];
	logic                         blk_free  [NBLK];
	int                           blk_count;
	logic [efba_pkg::HEAP_W-1:0]  bump_off;
	logic [efba_pkg::ADDR_W-1:0]  base_reg;
	logic [efba_pkg::HEAP_W-1:0]  start_reg;
	logic [efba_pkg::HEAP_W-1:0]  limit_reg;

	// Responses due from the block, oldest first.
	heap_rsp_t due_rsp [$];
	heap_row_t dir_rows [$];

	int tx_idle_pct;
	int rx_stall_pct;
	int clear_pct;
	logic rx_hold;
	event hold_start;

	int err_count;
	int n_sent;
	int n_reused;
	int n_cfg_writes;
	int status_seen [4];

	function automatic logic [efba_pkg::ADDR_W-1:0] payload_of(
			logic [efba_pkg::HEAP_W-1:0] off);
		return base_reg + {{(efba_pkg::ADDR_W - efba_pkg::HEAP_W){1'b0}}, off}
			+ efba_pkg::ADDR_W'(efba_pkg::HDR_BYTES);
	endfunction

	// Applies one request to the shadow heap and returns the response it earns.
	function automatic heap_rsp_t apply_heap_request(heap_req_t rq);
		heap_rsp_t r;
		logic [31:0] sz;
		logic [31:0] first;
		logic [31:0] last;
		int i;
		bit hit;
		r = '0;
		hit = 1'b0;
		case (rq.opcode)
		efba_pkg::OP_ALLOC: begin
			sz = ({8'd0, rq.req_size} + 32'd7) & ~32'd7;
			// Newest freed block of exactly this size wins.
			for (i = blk_count - 1; i >= 0; i--) begin
				if (!hit && blk_free[i] && {7'd0, blk_size[i]} == sz) begin
					blk_free[i] = 1'b0;
					r.addr = payload_of(blk_start[i]);
					r.reused = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				first = ({8'd0, bump_off} + 32'd3) & ~32'd3;
				last = first + 32'(efba_pkg::HDR_BYTES) + sz;
				if (last > {8'd0, limit_reg}) begin
					r.status = efba_pkg::ST_NO_ROOM;
				end else if (blk_count >= NBLK) begin
					r.status = efba_pkg::ST_FULL;
				end else begin
					blk_start[blk_count] = first[efba_pkg::HEAP_W-1:0];
					blk_size[blk_count] = sz[efba_pkg::RSIZE_W-1:0];
					blk_free[blk_count] = 1'b0;
					blk_count++;
					bump_off = last[efba_pkg::HEAP_W-1:0];
					r.addr = payload_of(first[efba_pkg::HEAP_W-1:0]);
				end
			end
		end
		efba_pkg::OP_FREE: begin
			for (i = blk_count - 1; i >= 0; i--) begin
				if (!hit && payload_of(blk_start[i]) == rq.free_addr) begin
					blk_free[i] = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit)
				r.status = efba_pkg::ST_IGNORED;
		end
		efba_pkg::OP_CLEAR: begin
			blk_count = 0;
			bump_off = start_reg;
		end
		default: begin
			r.status = efba_pkg::ST_IGNORED;
		end
		endcase
		return r;
	endfunction

	// Mostly well-formed traffic: small repeating sizes and frees of live blocks.
	function automatic heap_req_t next_random_req();
		heap_req_t rq;
		int roll;
		int pick;
		rq.opcode = efba_pkg::OP_ALLOC;
		rq.req_size = efba_pkg::SIZE_W'($urandom);
		rq.free_addr = $urandom;
		roll = $urandom_range(99);
		if (roll < clear_pct) begin
			rq.opcode = efba_pkg::OP_CLEAR;
		end else if (roll < clear_pct + 2) begin
			rq.opcode = OP_UNUSED;
		end else if (roll < 55) begin
			pick = $urandom_range(99);
			if (pick < 70)
				rq.req_size = efba_pkg::SIZE_W'($urandom_range(48));
			else if (pick < 92)
				rq.req_size = efba_pkg::SIZE_W'($urandom_range(1024));
		end else begin
			rq.opcode = efba_pkg::OP_FREE;
			if (blk_count > 0 && $urandom_range(9) < 7) begin
				pick = $urandom_range(blk_count - 1);
				rq.free_addr = payload_of(blk_start[pick]);
				// Now and then a near miss by one flipped bit.
				if ($urandom_range(9) == 0)
					rq.free_addr[$urandom_range(efba_pkg::ADDR_W - 1)] ^= 1'b1;
			end
		end
		return rq;
	endfunction

	task automatic add_row(logic [efba_pkg::OPCODE_W-1:0] op,
			logic [efba_pkg::SIZE_W-1:0] sz, logic [efba_pkg::ADDR_W-1:0] fa,
			logic typed, logic [efba_pkg::ADDR_W-1:0] a,
			logic [efba_pkg::STATUS_W-1:0] st, logic ru);
		heap_row_t row;
		row.req.opcode = op;
		row.req.req_size = sz;
		row.req.free_addr = fa;
		row.typed = typed;
		row.want.addr = a;
		row.want.status = st;
		row.want.reused = ru;
		dir_rows.push_back(row);
	endtask

	// Offers one request word, then records its expected response at acceptance.
	task automatic offer_word(heap_req_t rq, logic typed, heap_rsp_t want);
		heap_rsp_t got;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.opcode = rq.opcode;
		req_ch.req_size = rq.req_size;
		req_ch.free_addr = rq.free_addr;
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		got = apply_heap_request(rq);
		due_rsp.push_back(typed ? want : got);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [efba_pkg::REG_IDX_W-1:0] idx,
			logic [efba_pkg::CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		case (idx)
		efba_pkg::REG_MEMORY_BASE: base_reg = val;
		efba_pkg::REG_HEAP_START:  start_reg = val[efba_pkg::HEAP_W-1:0];
		efba_pkg::REG_HEAP_LIMIT:  limit_reg = val[efba_pkg::HEAP_W-1:0];
		default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
	endtask

	// Waits until every due response has arrived and the block has gone quiet.
	task automatic drain_block();
		req_ch.valid = 1'b0;
		while (due_rsp.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic flag_mismatch(string msg);
		err_count++;
		if (err_count <= SHOWN_ERRORS)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Receiver: random stalls, or a long hold-off while pressure is applied.
	always @(negedge clk) begin
		if (rx_hold)
			rsp_ch.ready = 1'b0;
		else
			rsp_ch.ready = ($urandom_range(99) >= rx_stall_pct);
	end

	// Long receiver hold-off, counted here so the sender keeps going meanwhile.
	initial begin
		rx_hold = 1'b0;
		@(hold_start);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	// Compare each response word with the oldest one due.
	always @(posedge clk) begin : rsp_check
		heap_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_rsp.size() == 0) begin
				flag_mismatch($sformatf("word with none due: addr %h status %0d reused %0b",
					rsp_ch.addr, rsp_ch.status, rsp_ch.reused));
			end else begin
				want = due_rsp.pop_front();
				if (rsp_ch.addr !== want.addr || rsp_ch.status !== want.status ||
						rsp_ch.reused !== want.reused)
					flag_mismatch($sformatf(
						"expected addr %h status %0d reused %0b, got addr %h status %0d reused %0b",
						want.addr, want.status, want.reused,
						rsp_ch.addr, rsp_ch.status, rsp_ch.reused));
			end
			status_seen[rsp_ch.status]++;
			if (rsp_ch.reused === 1'b1)
				n_reused++;
		end
	end

	initial begin
		#(TIMEOUT_CYC * CLK_PERIOD);
		$display("Timed out with %0d responses still due.", due_rsp.size());
		$display("exact_fit_reuse_bump_allocator: mismatch");
		$finish;
	end

	// Main sequence: reset, directed table, then random phases.
	initial begin : stimulus
		heap_rsp_t none;
		logic [efba_pkg::ADDR_W-1:0]  new_base;
		logic [efba_pkg::HEAP_W-1:0]  new_start;
		logic [efba_pkg::HEAP_W-1:0]  new_limit;
		logic [7:0]                   junk;
		int ph;
		int n;

		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = efba_pkg::REG_MEMORY_BASE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = efba_pkg::OP_ALLOC;
		req_ch.req_size = '0;
		req_ch.free_addr = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		clear_pct = 3;
		err_count = 0;
		n_sent = 0;
		n_reused = 0;
		n_cfg_writes = 0;
		foreach (status_seen[k])
			status_seen[k] = 0;

		// Shadow state after reset.
		base_reg = '0;
		start_reg = '0;
		limit_reg = {efba_pkg::HEAP_W{1'b1}};
		blk_count = 0;
		bump_off = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table under the reset register values.
		add_row(efba_pkg::OP_ALLOC, 24'h000000, 32'h0000_0000,
			1'b1, 32'h0000_0008, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h000001, 32'h0000_0000,
			1'b1, 32'h0000_0010, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'hFFFFFF, 32'h0000_0000,
			1'b1, 32'h0000_0000, efba_pkg::ST_NO_ROOM, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h0000_0010,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h0000_0010,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'hFFFF_FFFF,
			1'b1, 32'h0000_0000, efba_pkg::ST_IGNORED, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h000005, 32'h0000_0000,
			1'b1, 32'h0000_0010, efba_pkg::ST_OK, 1'b1);
		add_row(OP_UNUSED,          24'hFFFFFF, 32'hFFFF_FFFF,
			1'b1, 32'h0000_0000, efba_pkg::ST_IGNORED, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h0000_0008,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h000000, 32'h0000_0000,
			1'b1, 32'h0000_0008, efba_pkg::ST_OK, 1'b1);
		add_row(efba_pkg::OP_CLEAR, 24'h000000, 32'h0000_0000,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h0000_0008,
			1'b1, 32'h0000_0000, efba_pkg::ST_IGNORED, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'hFFFFF0, 32'h0000_0000,
			1'b1, 32'h0000_0008, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h000000, 32'h0000_0000,
			1'b1, 32'h0000_0000, efba_pkg::ST_NO_ROOM, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h000003, 32'h0000_0000,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h0000_0008,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'hFFFFEA, 32'h0000_0000,
			1'b1, 32'h0000_0008, efba_pkg::ST_OK, 1'b1);
		add_row(efba_pkg::OP_CLEAR, 24'hFFFFFF, 32'hFFFF_FFFF,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h000012, 32'h0000_0000,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h00000A, 32'h0000_0000,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h0000_0028,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'h055555, 32'hAAAA_AAAA,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_ALLOC, 24'hAAAAAA, 32'h5555_5555,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_FREE,  24'h000000, 32'h5555_5555,
			1'b0, '0, '0, 1'b0);
		add_row(efba_pkg::OP_CLEAR, 24'h000000, 32'h0000_0000,
			1'b1, 32'h0000_0000, efba_pkg::ST_OK, 1'b0);

		foreach (dir_rows[r])
			offer_word(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);

		// Random phases, each writing the registers and taking one of four idling patterns.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain_block();
			case (ph)
			0: begin new_base = 32'h0;        new_start = 24'h0;
				new_limit = 24'hFFFFFF; clear_pct = 3; end
			1: begin new_base = 32'hFFFF_FFFF; new_start = 24'h000005;
				new_limit = 24'h000800; clear_pct = 3; end
			2: begin new_base = 32'h8000_0000; new_start = 24'hFFFFFF;
				new_limit = 24'h000000; clear_pct = 2; end
			3: begin new_base = $urandom;
				new_start = efba_pkg::HEAP_W'($urandom_range(256));
				new_limit = 24'hFFFFFF; clear_pct = 0; end
			4: begin new_base = 32'h7FFF_FFFF; new_start = 24'h0;
				new_limit = 24'h0FFFFF; clear_pct = 3; end
			5: begin new_base = $urandom;
				new_start = efba_pkg::HEAP_W'($urandom_range(4095));
				new_limit = efba_pkg::HEAP_W'($urandom_range(24'hFFFFFF, 24'h000800));
				clear_pct = 4; end
			6: begin new_base = 32'h0;        new_start = 24'hFFFFE1;
				new_limit = 24'hFFFFFF; clear_pct = 6; end
			default: begin new_base = $urandom;
				new_start = efba_pkg::HEAP_W'($urandom_range(64));
				new_limit = 24'hFFFFFF; clear_pct = 2; end
			endcase
			// Upper bits of the heap registers carry junk that must be dropped.
			junk = 8'($urandom);
			write_reg(efba_pkg::REG_MEMORY_BASE, new_base);
			write_reg(efba_pkg::REG_HEAP_START, {junk, new_start});
			junk = 8'($urandom);
			write_reg(efba_pkg::REG_HEAP_LIMIT, {junk, new_limit});
			cfg_we = 1'b0;

			case (ph % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
			default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
			endcase
			if (ph == 4)
				-> hold_start;

			for (n = 0; n < PHASE_ITEMS; n++)
				offer_word(next_random_req(), 1'b0, none);
		end

		drain_block();
		$display("Sent %0d request words across %0d register settings; %0d reuses of freed blocks.",
			n_sent, NUM_PHASES + 1, n_reused);
		$display("Status seen: ok %0d, no room %0d, table full %0d, ignored %0d.",
			status_seen[efba_pkg::ST_OK], status_seen[efba_pkg::ST_NO_ROOM],
			status_seen[efba_pkg::ST_FULL], status_seen[efba_pkg::ST_IGNORED]);
		if (err_count == 0 && due_rsp.size() == 0)
			$display("exact_fit_reuse_bump_allocator: match");
		else
			$display("exact_fit_reuse_bump_allocator: mismatch");
		$finish;
	end

endmodule
